### design/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared widths, codes and helpers of the texture resampling sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    localparam int STORE_TEXELS = 4096;
    localparam int ADDR_BITS    = $clog2(STORE_TEXELS);
    localparam int CHANNEL_BITS = 16;
    localparam int WEIGHT_BITS  = 8;
    localparam int TEXEL_BITS   = 4 * CHANNEL_BITS;
    localparam int SIZE_BITS    = 13;
    localparam int COORD_BITS   = 12;
    localparam int NUM_BITS     = COORD_BITS + SIZE_BITS;
    localparam int DVD_BITS     = NUM_BITS + WEIGHT_BITS;
    localparam int DVS_BITS     = SIZE_BITS + 1;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [SIZE_BITS-1:0] MAX_SIZE = SIZE_BITS'(4096);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_W  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_H  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_D  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_W  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_H  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_D  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINEAR = 3'd6;

    typedef logic [TEXEL_BITS-1:0] t_texel;

    // zero reads as one, anything past the largest size saturates
    function automatic logic [SIZE_BITS-1:0] size_sat(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] r;
        if (v == '0) begin
            r = SIZE_BITS'(1);
        end else if (v > MAX_SIZE) begin
            r = MAX_SIZE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/trs_if.sv
// ----------------------------------------------------------------------------
// trs_if
// Valid/ready stream interfaces for the sampler command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface trs_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] texel_index;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
    logic [15:0] in_alpha;
    logic [11:0] target_x;
    logic [11:0] target_y;
    logic [11:0] target_z;

    modport source (output valid, command, texel_index, in_red, in_green, in_blue,
                    in_alpha, target_x, target_y, target_z, input ready);
    modport sink   (input valid, command, texel_index, in_red, in_green, in_blue,
                    in_alpha, target_x, target_y, target_z, output ready);
endinterface

interface trs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

`default_nettype wire

### design/trs_div.sv
// ----------------------------------------------------------------------------
// trs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [trs_pkg::DVD_BITS-1:0]  i_dividend,
    input  wire [trs_pkg::DVS_BITS-1:0]  i_divisor,
    output logic                         o_done,
    output logic [trs_pkg::DVD_BITS-1:0] o_quotient
);
    import trs_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    logic [DVD_BITS-1:0] r_quo;
    logic [DVS_BITS-1:0] r_rem;
    logic [DVS_BITS-1:0] r_dvs;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DVS_BITS:0]   trial;
    logic [DVS_BITS:0]   diff;
    logic                fits;

    assign trial = {r_rem, r_quo[DVD_BITS-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DVD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_BITS-2:0], fits};
            r_rem <= fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### design/trs_texel_mem.sv
// ----------------------------------------------------------------------------
// trs_texel_mem
// Texel store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_texel_mem (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire [trs_pkg::ADDR_BITS-1:0]  i_waddr,
    input  wire [trs_pkg::TEXEL_BITS-1:0] i_wdata,
    input  wire                           i_re,
    input  wire [trs_pkg::ADDR_BITS-1:0]  i_raddr,
    output logic [trs_pkg::TEXEL_BITS-1:0] o_rdata
);
    import trs_pkg::*;

    t_texel r_mem [STORE_TEXELS];
    t_texel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/texture_resample_sampler.sv
// ----------------------------------------------------------------------------
// texture_resample_sampler
// Texel store with a nearest / trilinear sampler of a resized view.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries transactions: command write stores one texel at texel_index
//   and yields no result; command sample yields one result on o_out.
//   A write is stored and the block stays ready.
//   A sample runs per axis one multiply plus a division in the shared
//   divider, then reads each texel through the single memory read port
//   in the row, address and data states (1 texel nearest, 8 trilinear),
//   then in trilinear mode blends, one channel step per cycle on the one
//   blend multiplier.
//   i_in.ready is low while a sample is in work.
//   Results sit in an output register; the next transaction is accepted while
//   a result waits. If the receiver stalls with a result still held, a
//   finished sample waits until the register frees.
//   Reset clears control state and sets all sizes to 1 and nearest mode;
//   the store content is undefined until written. The user must write
//   configuration via i_cfg_* only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module texture_resample_sampler (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [trs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire [trs_pkg::SIZE_BITS-1:0]    i_cfg_data,
    trs_in_if.sink                          i_in,
    trs_out_if.source                       o_out
);
    import trs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_DIVGO  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_ROW    = 4'd4;
    localparam logic [3:0] S_ADDR   = 4'd5;
    localparam logic [3:0] S_DATA   = 4'd6;
    localparam logic [3:0] S_BLEND  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam int BLEND_STEPS = 28;

    // configuration
    logic [SIZE_BITS-1:0] r_src_w, r_src_h, r_src_d;
    logic [SIZE_BITS-1:0] r_dst_w, r_dst_h, r_dst_d;
    logic                 r_linear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= SIZE_BITS'(1);
            r_src_h  <= SIZE_BITS'(1);
            r_src_d  <= SIZE_BITS'(1);
            r_dst_w  <= SIZE_BITS'(1);
            r_dst_h  <= SIZE_BITS'(1);
            r_dst_d  <= SIZE_BITS'(1);
            r_linear <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_W:  r_src_w  <= size_sat(i_cfg_data);
                CFG_SRC_H:  r_src_h  <= size_sat(i_cfg_data);
                CFG_SRC_D:  r_src_d  <= size_sat(i_cfg_data);
                CFG_DST_W:  r_dst_w  <= size_sat(i_cfg_data);
                CFG_DST_H:  r_dst_h  <= size_sat(i_cfg_data);
                CFG_DST_D:  r_dst_d  <= size_sat(i_cfg_data);
                CFG_LINEAR: r_linear <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state
    logic [3:0]            r_state, n_state;
    logic [1:0]            r_axis;
    logic [2:0]            r_k;
    logic [4:0]            r_step;
    logic [COORD_BITS-1:0] r_coord [3];
    logic [COORD_BITS-1:0] r_idx0 [3];
    logic [COORD_BITS-1:0] r_idx1 [3];
    logic [WEIGHT_BITS-1:0] r_wgt [3];
    logic [NUM_BITS-1:0]   r_num;
    logic [ADDR_BITS-1:0]  r_row;
    t_texel                r_tex [8];
    logic                  r_out_valid;
    t_texel                r_out;

    logic in_acc, wr_acc, smp_acc;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign wr_acc     = in_acc && (i_in.command == CMD_WRITE);
    assign smp_acc    = in_acc && (i_in.command == CMD_SAMPLE);

    // per-axis selection
    logic [COORD_BITS-1:0] d_sel;
    logic [SIZE_BITS-1:0]  src_sel, dst_sel;
    always_comb begin
        case (r_axis)
            2'd0: begin src_sel = r_src_w; dst_sel = r_dst_w; end
            2'd1: begin src_sel = r_src_h; dst_sel = r_dst_h; end
            default: begin src_sel = r_src_d; dst_sel = r_dst_d; end
        endcase
        d_sel = r_coord[r_axis];
    end

    logic [COORD_BITS-1:0] src_max;
    assign src_max = COORD_BITS'(src_sel - SIZE_BITS'(1));

    // divider
    logic                div_start, div_done;
    logic [DVD_BITS-1:0] div_dvd, div_q;
    logic [DVS_BITS-1:0] div_dvs;
    assign div_start = (r_state == S_DIVGO);
    assign div_dvd = r_linear ? {r_num, {WEIGHT_BITS{1'b0}}}
                              : DVD_BITS'({r_num, 1'b0}) + DVD_BITS'(dst_sel);
    assign div_dvs = r_linear ? {1'b0, dst_sel} : {dst_sel, 1'b0};

    trs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    logic [COORD_BITS-1:0] lin_i0;
    logic [COORD_BITS:0]   lin_i0p1;
    logic [COORD_BITS-1:0] lin_i1;
    logic [COORD_BITS-1:0] near_i;
    assign lin_i0   = div_q[WEIGHT_BITS +: COORD_BITS];
    assign lin_i0p1 = {1'b0, lin_i0} + 1'b1;
    assign lin_i1   = (lin_i0p1 > {1'b0, src_max}) ? src_max : lin_i0p1[COORD_BITS-1:0];
    assign near_i   = (div_q > DVD_BITS'(src_max)) ? src_max : div_q[COORD_BITS-1:0];

    // texel addressing: only the low address bits matter, the store wraps
    logic [COORD_BITS-1:0] x_sel, y_sel, z_sel;
    logic [2*ADDR_BITS-1:0] row_prod, addr_prod;
    logic [ADDR_BITS-1:0]  rd_addr;
    assign x_sel     = r_k[0] ? r_idx1[0] : r_idx0[0];
    assign y_sel     = r_k[1] ? r_idx1[1] : r_idx0[1];
    assign z_sel     = r_k[2] ? r_idx1[2] : r_idx0[2];
    assign row_prod  = z_sel * r_src_h[ADDR_BITS-1:0];
    assign addr_prod = r_row * r_src_w[ADDR_BITS-1:0];
    assign rd_addr   = addr_prod[ADDR_BITS-1:0] + x_sel;

    t_texel mem_rdata;
    trs_texel_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_acc),
        .i_waddr (i_in.texel_index),
        .i_wdata ({i_in.in_alpha, i_in.in_blue, i_in.in_green, i_in.in_red}),
        .i_re    (r_state == S_ADDR),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // blend unit: one channel of one pair per cycle
    logic [2:0]             bl_pass;
    logic [1:0]             bl_ch;
    logic [2:0]             bl_a, bl_b;
    logic [WEIGHT_BITS-1:0] bl_w;
    logic [CHANNEL_BITS-1:0] va, vb, vr;
    logic signed [CHANNEL_BITS:0]             diff;
    logic signed [CHANNEL_BITS+WEIGHT_BITS+1:0] prod;
    logic signed [CHANNEL_BITS+1:0]           sum;
    assign bl_pass = r_step[4:2];
    assign bl_ch   = r_step[1:0];
    always_comb begin
        case (bl_pass)
            3'd0:    begin bl_a = 3'd0; bl_b = 3'd1; bl_w = r_wgt[0]; end
            3'd1:    begin bl_a = 3'd2; bl_b = 3'd3; bl_w = r_wgt[0]; end
            3'd2:    begin bl_a = 3'd4; bl_b = 3'd5; bl_w = r_wgt[0]; end
            3'd3:    begin bl_a = 3'd6; bl_b = 3'd7; bl_w = r_wgt[0]; end
            3'd4:    begin bl_a = 3'd0; bl_b = 3'd2; bl_w = r_wgt[1]; end
            3'd5:    begin bl_a = 3'd4; bl_b = 3'd6; bl_w = r_wgt[1]; end
            default: begin bl_a = 3'd0; bl_b = 3'd4; bl_w = r_wgt[2]; end
        endcase
    end
    assign va   = r_tex[bl_a][bl_ch*CHANNEL_BITS +: CHANNEL_BITS];
    assign vb   = r_tex[bl_b][bl_ch*CHANNEL_BITS +: CHANNEL_BITS];
    assign diff = $signed({1'b0, vb}) - $signed({1'b0, va});
    assign prod = diff * $signed({1'b0, bl_w});
    assign sum  = $signed({2'b00, va}) + (CHANNEL_BITS+2)'(prod >>> WEIGHT_BITS);
    assign vr   = sum[CHANNEL_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (smp_acc) n_state = S_MUL;
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (div_done) n_state = (r_axis == 2'd2) ? S_ROW : S_MUL;
            S_ROW:   n_state = S_ADDR;
            S_ADDR:  n_state = S_DATA;
            S_DATA: begin
                if (!r_linear) begin
                    n_state = S_DONE;
                end else if (r_k == 3'd7) begin
                    n_state = S_BLEND;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_BLEND: if (r_step == 5'(BLEND_STEPS - 1)) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_axis <= 2'd0;
                r_k    <= 3'd0;
                r_step <= '0;
                r_coord[0] <= ({1'b0, i_in.target_x} >= r_dst_w)
                              ? COORD_BITS'(r_dst_w - 1'b1) : i_in.target_x;
                r_coord[1] <= ({1'b0, i_in.target_y} >= r_dst_h)
                              ? COORD_BITS'(r_dst_h - 1'b1) : i_in.target_y;
                r_coord[2] <= ({1'b0, i_in.target_z} >= r_dst_d)
                              ? COORD_BITS'(r_dst_d - 1'b1) : i_in.target_z;
            end
            S_MUL: r_num <= d_sel * src_sel;
            S_DIV: begin
                if (div_done) begin
                    if (r_linear) begin
                        r_idx0[r_axis] <= lin_i0;
                        r_idx1[r_axis] <= lin_i1;
                        r_wgt[r_axis]  <= div_q[WEIGHT_BITS-1:0];
                    end else begin
                        r_idx0[r_axis] <= near_i;
                        r_idx1[r_axis] <= near_i;
                        r_wgt[r_axis]  <= '0;
                    end
                    r_axis <= r_axis + 1'b1;
                end
            end
            S_ROW: r_row <= row_prod[ADDR_BITS-1:0] + y_sel;
            S_DATA: begin
                r_tex[r_k] <= mem_rdata;
                r_k        <= r_k + 1'b1;
            end
            S_BLEND: begin
                r_tex[bl_a][bl_ch*CHANNEL_BITS +: CHANNEL_BITS] <= vr;
                r_step <= r_step + 1'b1;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out <= r_tex[0];
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_red   = r_out[0*CHANNEL_BITS +: CHANNEL_BITS];
    assign o_out.out_green = r_out[1*CHANNEL_BITS +: CHANNEL_BITS];
    assign o_out.out_blue  = r_out[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign o_out.out_alpha = r_out[3*CHANNEL_BITS +: CHANNEL_BITS];

endmodule

`default_nettype wire

### design/trs_checker.sv
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks of the sampler handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_in_command,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [63:0] i_out_data
);
    import trs_pkg::*;

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("result or busy after reset");

    // a sample transaction makes the block busy
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_SAMPLE) |=> !i_in_ready)
        else $error("ready right after sample");

    // a texel write never blocks the next transaction
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_WRITE) |=> i_in_ready)
        else $error("busy after texel write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind texture_resample_sampler trs_checker u_trs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_data   ({o_out.out_alpha, o_out.out_blue, o_out.out_green, o_out.out_red})
);

`default_nettype wire
